// File: rtl/cnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnm_pkg
// Shared types and constants of the cosine nearest-match block.
// ----------------------------------------------------------------------------
package cnm_pkg;

    localparam int MAX_DIM     = 128;
    localparam int MAX_ENTRIES = 256;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int ENT_W       = $clog2(MAX_ENTRIES);
    localparam int ADDR_W      = ENT_W + DIM_W;
    localparam int LEN_W       = DIM_W + 1;
    localparam int CNT_W       = ENT_W + 1;

    // Sum of MAX_DIM products of two Q1.15 values, signed and unsigned.
    localparam int DOT_W = 32 + DIM_W;
    localparam int NRM_W = 31 + DIM_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_VLEN      = 2'd1;
    localparam logic [1:0] REG_ENTRIES   = 2'd2;

    localparam logic signed [15:0] THRESHOLD_RST = 16'sd19661;
    localparam logic [7:0]         VLEN_RST      = 8'd128;
    localparam logic [8:0]         ENTRIES_RST   = 9'd0;
    localparam logic signed [15:0] SCORE_MIN     = 16'sh8000;

    typedef struct packed {
        logic               command;
        logic [7:0]         entry;
        logic [6:0]         position;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic               matched;
        logic [7:0]         best_entry;
        logic signed [15:0] similarity;
    } out_item_t;

endpackage

// File: rtl/cnm_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnm_score
// Turns dot product and two squared norms into a saturated Q1.15 cosine:
// partial-product multiply, bit-serial square root, restoring division.
// ----------------------------------------------------------------------------
module cnm_score (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cnm_pkg::DOT_W-1:0]  dot,
    input  logic [cnm_pkg::NRM_W-1:0]         norm_a,
    input  logic [cnm_pkg::NRM_W-1:0]         norm_b,
    output logic                              done,
    output logic signed [15:0]                score
);

    localparam int HW      = 19;
    localparam int PROD_W  = 76;
    localparam int ROOT_W  = 38;
    localparam int NUM_W   = 54;
    localparam int QB      = 17;
    localparam int DOT_W_L = cnm_pkg::DOT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SQRT  = 6'b000100,
        S_DPREP = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } sc_state_t;

    sc_state_t           state_reg;
    logic [2:0]          mcnt_reg;
    logic [1:0]          psel_reg;
    logic [5:0]          scnt_reg;
    logic                neg_reg;
    logic [ROOT_W-1:0]   mag_reg;
    logic [ROOT_W-1:0]   na_reg;
    logic [ROOT_W-1:0]   nb_reg;
    logic [2*HW-1:0]     prod_reg;
    logic [PROD_W-1:0]   rad_reg;
    logic [39:0]         rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [38:0]         dr_reg;
    logic [QB-1:0]       nq_reg;
    logic signed [15:0]  score_reg;

    logic [HW-1:0]       a_half;
    logic [HW-1:0]       b_half;
    logic [PROD_W-1:0]   prod_sh;
    logic [41:0]         rem_sh;
    logic [41:0]         trial;
    logic [38:0]         dr_sh;
    logic [NUM_W-1:0]    num;
    logic [DOT_W_L-1:0]  dot_abs;

    assign a_half = mcnt_reg[1] ? na_reg[2*HW-1:HW] : na_reg[HW-1:0];
    assign b_half = mcnt_reg[0] ? nb_reg[2*HW-1:HW] : nb_reg[HW-1:0];

    always_comb
    begin
        case (psel_reg)
            2'd0:    prod_sh = PROD_W'(prod_reg);
            2'd1:    prod_sh = PROD_W'(prod_reg) << HW;
            2'd2:    prod_sh = PROD_W'(prod_reg) << HW;
            2'd3:    prod_sh = PROD_W'(prod_reg) << (2 * HW);
            default: prod_sh = PROD_W'(prod_reg);
        endcase
    end

    assign rem_sh  = {rem_reg, rad_reg[PROD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign dr_sh   = {dr_reg[37:0], nq_reg[QB-1]};
    assign num     = (NUM_W'(mag_reg) << 15) + NUM_W'(root_reg >> 1);
    assign dot_abs = dot[DOT_W_L-1] ? DOT_W_L'(-dot) : DOT_W_L'(dot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (norm_a == '0 || norm_b == '0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:   if (mcnt_reg == 3'd4) state_reg <= S_SQRT;
                S_SQRT:  if (scnt_reg == 6'(ROOT_W - 1)) state_reg <= S_DPREP;
                S_DPREP: state_reg <= S_DIV;
                S_DIV:   if (scnt_reg == 6'(QB - 1)) state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                neg_reg   <= dot[DOT_W_L-1];
                mag_reg   <= ROOT_W'(dot_abs);
                na_reg    <= ROOT_W'(norm_a);
                nb_reg    <= ROOT_W'(norm_b);
                mcnt_reg  <= '0;
                rad_reg   <= '0;
                score_reg <= '0;
            end
            S_MUL:
            begin
                if (mcnt_reg != 3'd4)
                begin
                    prod_reg <= a_half * b_half;
                    psel_reg <= mcnt_reg[1:0];
                end
                if (mcnt_reg != 3'd0)
                    rad_reg <= rad_reg + prod_sh;
                mcnt_reg <= mcnt_reg + 3'd1;
                scnt_reg <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 40'(rem_sh - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[39:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_reg  <= rad_reg << 2;
                scnt_reg <= scnt_reg + 6'd1;
            end
            S_DPREP:
            begin
                dr_reg   <= 39'(num[NUM_W-1:QB]);
                nq_reg   <= num[QB-1:0];
                scnt_reg <= '0;
            end
            S_DIV:
            begin
                if (dr_sh >= {1'b0, root_reg})
                begin
                    dr_reg <= dr_sh - {1'b0, root_reg};
                    nq_reg <= {nq_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    dr_reg <= dr_sh;
                    nq_reg <= {nq_reg[QB-2:0], 1'b0};
                end
                scnt_reg <= scnt_reg + 6'd1;
            end
            S_DONE:
            begin
                // Only the zero-norm path skips the divider; score_reg is then 0.
                if (mcnt_reg == 3'd5)
                begin
                    if (neg_reg)
                        score_reg <= (nq_reg >= 17'd32768) ? 16'sh8000
                                                           : 16'(-nq_reg);
                    else
                        score_reg <= (nq_reg >= 17'd32767) ? 16'sh7fff
                                                           : 16'(nq_reg);
                end
            end
            default: ;
        endcase
        if (state_reg == S_DIV && scnt_reg == 6'(QB - 1))
            mcnt_reg <= 3'd5;
    end

    // The result is registered from S_DONE, so done is registered from S_DONE too and rises with it.
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_DONE);
    end

    assign done  = done_reg;
    assign score = score_reg;

endmodule

// File: rtl/cosine_nearest_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_nearest_match
// Stores reference vectors and finds the one closest to a query by cosine.
// ----------------------------------------------------------------------------
// Load and query transfers are accepted only while the block is idle.
// The final query element starts a search over the entries in use, one entry
// at a time: one memory read per element, a drain of the read and product registers,
// then the shared multiply, square-root and divide unit; an entry with a zero norm
// skips that unit. T_FIN issues the result once any earlier result has been taken.
// Reset clears control state and the configuration registers; stored vectors are undefined
// until written.
module cosine_nearest_match (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cnm_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cnm_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_ACC   = 5'b00010,
        T_DRAIN = 5'b00100,
        T_SCORE = 5'b01000,
        T_FIN   = 5'b10000
    } top_state_t;

    top_state_t                       state_reg;
    logic signed [15:0]               thr_reg;
    logic [7:0]                       vlen_reg;
    logic [8:0]                       eiu_reg;
    logic [cnm_pkg::LEN_W-1:0]        len_reg;
    logic [cnm_pkg::CNT_W-1:0]        count_reg;
    logic [cnm_pkg::CNT_W-1:0]        ent_reg;
    logic [cnm_pkg::LEN_W-1:0]        idx_reg;
    logic                             zero_reg;
    logic                             v1_reg;
    logic                             v2_reg;
    logic signed [15:0]               q_rd_reg;
    logic signed [15:0]               r_rd_reg;
    logic signed [31:0]               pd_reg;
    logic [31:0]                      pa_reg;
    logic [31:0]                      pb_reg;
    logic signed [cnm_pkg::DOT_W-1:0] dot_reg;
    logic [cnm_pkg::NRM_W-1:0]        na_reg;
    logic [cnm_pkg::NRM_W-1:0]        nb_reg;
    logic signed [15:0]               best_reg;
    logic [cnm_pkg::ENT_W-1:0]        bidx_reg;
    logic                             out_valid_reg;
    cnm_pkg::out_item_t               out_reg;

    logic signed [15:0] ref_mem [0:cnm_pkg::MAX_ENTRIES*cnm_pkg::MAX_DIM-1];
    logic signed [15:0] qry_mem [0:cnm_pkg::MAX_DIM-1];

    logic                             in_fire;
    logic                             is_last;
    logic [cnm_pkg::LEN_W-1:0]        eff_len;
    logic [cnm_pkg::CNT_W-1:0]        eff_cnt;
    logic                             sc_start;
    logic                             sc_done;
    logic signed [15:0]               sc_score;

    assign in_ready  = (state_reg == T_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign eff_len = (vlen_reg == 8'd0) ? cnm_pkg::LEN_W'(1)
                   : (vlen_reg > 8'(cnm_pkg::MAX_DIM)) ? cnm_pkg::LEN_W'(cnm_pkg::MAX_DIM)
                   : cnm_pkg::LEN_W'(vlen_reg);
    assign eff_cnt = (eiu_reg > 9'(cnm_pkg::MAX_ENTRIES)) ? cnm_pkg::CNT_W'(cnm_pkg::MAX_ENTRIES)
                   : cnm_pkg::CNT_W'(eiu_reg);
    assign is_last = (in_item.command == cnm_pkg::CMD_QUERY)
                  && (cnm_pkg::LEN_W'(in_item.position) == eff_len - 1'b1);

    assign sc_start = (state_reg == T_DRAIN) && !v1_reg && !v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= cnm_pkg::THRESHOLD_RST;
            vlen_reg <= cnm_pkg::VLEN_RST;
            eiu_reg  <= cnm_pkg::ENTRIES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cnm_pkg::REG_THRESHOLD: thr_reg  <= cfg_data;
                cnm_pkg::REG_VLEN:      vlen_reg <= cfg_data[7:0];
                cnm_pkg::REG_ENTRIES:   eiu_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_item.command == cnm_pkg::CMD_LOAD)
            ref_mem[{in_item.entry, in_item.position}] <= in_item.value;
        r_rd_reg <= ref_mem[{ent_reg[cnm_pkg::ENT_W-1:0], idx_reg[cnm_pkg::DIM_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_item.command == cnm_pkg::CMD_QUERY)
            qry_mem[in_item.position] <= in_item.value;
        q_rd_reg <= qry_mem[idx_reg[cnm_pkg::DIM_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        pd_reg <= q_rd_reg * r_rd_reg;
        pa_reg <= 32'(q_rd_reg * q_rd_reg);
        pb_reg <= 32'(r_rd_reg * r_rd_reg);
        if (state_reg != T_ACC && state_reg != T_DRAIN)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else if (v2_reg)
        begin
            dot_reg <= dot_reg + cnm_pkg::DOT_W'(pd_reg);
            na_reg  <= na_reg + cnm_pkg::NRM_W'(pa_reg);
            nb_reg  <= nb_reg + cnm_pkg::NRM_W'(pb_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == T_ACC);
            v2_reg <= v1_reg;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (in_fire && is_last)
                    begin
                        len_reg   <= eff_len;
                        count_reg <= eff_cnt;
                        ent_reg   <= '0;
                        idx_reg   <= '0;
                        best_reg  <= cnm_pkg::SCORE_MIN;
                        bidx_reg  <= '0;
                        zero_reg  <= (eff_cnt == '0);
                        state_reg <= (eff_cnt == '0) ? T_FIN : T_ACC;
                    end
                end
                T_ACC:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == len_reg - 1'b1)
                        state_reg <= T_DRAIN;
                end
                T_DRAIN:
                begin
                    if (sc_start)
                        state_reg <= T_SCORE;
                end
                T_SCORE:
                begin
                    if (sc_done)
                    begin
                        if (sc_score > best_reg)
                        begin
                            best_reg <= sc_score;
                            bidx_reg <= ent_reg[cnm_pkg::ENT_W-1:0];
                        end
                        idx_reg <= '0;
                        ent_reg <= ent_reg + 1'b1;
                        state_reg <= (ent_reg + 1'b1 == count_reg) ? T_FIN : T_ACC;
                    end
                end
                T_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.best_entry <= bidx_reg;
                        out_reg.similarity <= zero_reg ? 16'sd0 : best_reg;
                        out_reg.matched    <= !zero_reg && (best_reg >= thr_reg);
                        state_reg          <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    cnm_score u_score (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sc_start),
        .dot    (dot_reg),
        .norm_a (na_reg),
        .norm_b (nb_reg),
        .done   (sc_done),
        .score  (sc_score)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: verif/tb_cosine_nearest_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_nearest_match
// Self-checking bench for the cosine nearest-match search block.
// Stored vectors are loaded, and then queries are streamed. Each search
// result is checked against a cycle-free score model. The configuration
// moves through several thresholds, vector lengths and entry counts. Both
// channels idle at random, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_cosine_nearest_match;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cnm_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_ready;
    cnm_pkg::out_item_t out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    cosine_nearest_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Score model state.
    logic signed [15:0] mdl_store [cnm_pkg::MAX_ENTRIES][cnm_pkg::MAX_DIM];
    logic signed [15:0] mdl_query [cnm_pkg::MAX_DIM];
    logic signed [15:0] mdl_threshold;
    logic [7:0]         mdl_vlen;
    logic [8:0]         mdl_entries;

    // Copy of the vectors the stimulus has loaded, used to build related queries.
    logic signed [15:0] loaded_vec [cnm_pkg::MAX_ENTRIES][cnm_pkg::MAX_DIM];

    cnm_pkg::in_item_t  pending_items[$];
    cnm_pkg::out_item_t expected_matches[$];
    int        items_pushed;
    int        items_accepted;
    int        results_seen;
    int        mismatches;
    int        idle_cycles;
    logic      calm;
    int        calm_cnt;
    int        send_gap;
    int        recv_gap;
    int        hold_cnt;
    logic      held;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_len(input logic [7:0] vl);
        if (vl == 8'd0) return 1;
        if (vl > cnm_pkg::MAX_DIM) return cnm_pkg::MAX_DIM;
        return int'(vl);
    endfunction

    function automatic logic signed [15:0] cosine_score(input int e, input int len);
        logic signed [63:0] dot;
        logic signed [63:0] na;
        logic signed [63:0] nb;
        logic [127:0]       prod;
        logic [127:0]       cand;
        logic [63:0]        root;
        logic [63:0]        mag;
        logic [63:0]        quo;
        dot  = 0;
        na   = 0;
        nb   = 0;
        root = 0;
        for (int i = 0; i < len; i++) begin
            dot += 64'(mdl_query[i]) * 64'(mdl_store[e][i]);
            na  += 64'(mdl_query[i]) * 64'(mdl_query[i]);
            nb  += 64'(mdl_store[e][i]) * 64'(mdl_store[e][i]);
        end
        if (na == 0 || nb == 0) return 16'sd0;
        prod = 128'(na) * 128'(nb);
        for (int b = 41; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= prod) root = cand[63:0];
        end
        if (root == 0) return 16'sd0;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        quo = (mag * 64'd32768 + root / 2) / root;
        if (dot < 0) begin
            if (quo > 64'd32768) quo = 64'd32768;
            return 16'(-quo);
        end
        if (quo > 64'd32767) quo = 64'd32767;
        return 16'(quo);
    endfunction

    // Applies one accepted input transfer to the model and queues any result.
    task automatic predict_match(input cnm_pkg::in_item_t it);
        int                 len;
        int                 cnt;
        logic signed [15:0] best;
        logic signed [15:0] s;
        logic [7:0]         best_idx;
        cnm_pkg::out_item_t r;
        if (it.command == cnm_pkg::CMD_LOAD) begin
            mdl_store[it.entry][it.position] = it.value;
        end else begin
            mdl_query[it.position] = it.value;
            len = eff_len(mdl_vlen);
            if (int'(it.position) == len - 1) begin
                cnt = (mdl_entries > cnm_pkg::MAX_ENTRIES) ? cnm_pkg::MAX_ENTRIES
                                                           : int'(mdl_entries);
                best     = cnm_pkg::SCORE_MIN;
                best_idx = 8'd0;
                if (cnt == 0) begin
                    r = '0;
                end else begin
                    for (int e = 0; e < cnt; e++) begin
                        s = cosine_score(e, len);
                        if (s > best) begin
                            best     = s;
                            best_idx = 8'(e);
                        end
                    end
                    r.matched    = (best >= mdl_threshold);
                    r.best_entry = best_idx;
                    r.similarity = best;
                end
                expected_matches.push_back(r);
            end
        end
    endtask

    // Sender.
    always @(posedge clk or negedge rst_n) begin
        logic              nv;
        cnm_pkg::in_item_t ni;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            in_item   <= '0;
            send_gap  = 0;
            calm      = 1'b0;
            calm_cnt  = 0;
        end else begin
            calm_cnt++;
            if (calm_cnt >= 400) begin
                calm_cnt = 0;
                calm     = ($urandom_range(0, 2) == 0);
            end
            nv = in_valid;
            ni = in_item;
            if (in_valid && in_ready) begin
                predict_match(in_item);
                items_accepted++;
                nv = 1'b0;
                if (!calm) begin
                    if ($urandom_range(0, 9) < 7) send_gap = 0;
                    else if ($urandom_range(0, 9) < 8) send_gap = $urandom_range(1, 3);
                    else send_gap = $urandom_range(10, 60);
                end
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    ni = pending_items.pop_front();
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
            in_item  <= ni;
        end
    end

    // Receiver and result check.
    always @(posedge clk or negedge rst_n) begin
        cnm_pkg::out_item_t exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap  = 0;
            hold_cnt  = 0;
            held      = 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_matches.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %p", out_item);
                end else begin
                    exp_r = expected_matches.pop_front();
                    if (out_item.matched !== exp_r.matched
                        || out_item.best_entry !== exp_r.best_entry
                        || out_item.similarity !== exp_r.similarity) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch expected m=%0b e=%0d s=%0d,",
                                      " got m=%0b e=%0d s=%0d"},
                                     exp_r.matched, exp_r.best_entry, exp_r.similarity,
                                     out_item.matched, out_item.best_entry,
                                     out_item.similarity);
                    end
                end
            end
            if (!held && results_seen == 3) begin
                // Long back-pressure while more queries are queued.
                held     = 1'b1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (calm) begin
                out_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 9) < 7) recv_gap = 0;
                else if ($urandom_range(0, 9) < 8) recv_gap = $urandom_range(1, 3);
                else recv_gap = $urandom_range(10, 60);
                out_ready <= (recv_gap == 0);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic cmd, input int ent, input int pos,
                             input logic signed [15:0] val);
        cnm_pkg::in_item_t it;
        it.command  = cmd;
        it.entry    = 8'(ent);
        it.position = 7'(pos);
        it.value    = val;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic wait_idle();
        while (items_accepted != items_pushed || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            cnm_pkg::REG_THRESHOLD: mdl_threshold = data;
            cnm_pkg::REG_VLEN:      mdl_vlen      = data[7:0];
            cnm_pkg::REG_ENTRIES:   mdl_entries   = data[8:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One configuration setting: load every searched entry, then run queries.
    task automatic run_phase(input logic signed [15:0] thr, input logic [7:0] vl,
                             input logic [8:0] ne, input int nq);
        int                 len;
        int                 cnt;
        int                 mode;
        int                 src;
        logic signed [15:0] v;
        wait_idle();
        write_cfg(cnm_pkg::REG_THRESHOLD, thr);
        write_cfg(cnm_pkg::REG_VLEN, {8'd0, vl});
        write_cfg(cnm_pkg::REG_ENTRIES, {7'd0, ne});
        len = eff_len(vl);
        cnt = (ne > cnm_pkg::MAX_ENTRIES) ? cnm_pkg::MAX_ENTRIES : int'(ne);
        for (int e = 0; e < cnt; e++) begin
            mode = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
                if (mode == 0 && e > 0) v = loaded_vec[0][i];
                else if (mode == 1) v = 16'sd0;
                else if (mode == 2 && e > 0) v = -loaded_vec[0][i];
                else v = rand_value();
                loaded_vec[e][i] = v;
                push_item(cnm_pkg::CMD_LOAD, e, i, v);
            end
        end
        for (int q = 0; q < nq; q++) begin
            mode = $urandom_range(0, 5);
            src  = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (mode == 0 && cnt > 0) v = loaded_vec[src][i];
                else if (mode == 1 && cnt > 0) v = -loaded_vec[src][i];
                else if (mode == 2) v = 16'sd0;
                else v = rand_value();
                // Stray transfers outside the searched length leave the result unchanged.
                if (len < cnm_pkg::MAX_DIM && $urandom_range(0, 9) == 0)
                    push_item(cnm_pkg::CMD_LOAD, $urandom_range(0, 255),
                              $urandom_range(len, cnm_pkg::MAX_DIM - 1), rand_value());
                if (len < cnm_pkg::MAX_DIM && $urandom_range(0, 9) == 0)
                    push_item(cnm_pkg::CMD_QUERY, $urandom_range(0, 255),
                              $urandom_range(len, cnm_pkg::MAX_DIM - 1), rand_value());
                push_item(cnm_pkg::CMD_QUERY, $urandom_range(0, 255), i, v);
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        items_pushed   = 0;
        items_accepted = 0;
        results_seen   = 0;
        mismatches     = 0;
        mdl_threshold  = cnm_pkg::THRESHOLD_RST;
        mdl_vlen       = cnm_pkg::VLEN_RST;
        mdl_entries    = cnm_pkg::ENTRIES_RST;
        for (int i = 0; i < cnm_pkg::MAX_DIM; i++) mdl_query[i] = '0;
        for (int e = 0; e < cnm_pkg::MAX_ENTRIES; e++)
            for (int i = 0; i < cnm_pkg::MAX_DIM; i++) begin
                mdl_store[e][i]  = '0;
                loaded_vec[e][i] = '0;
            end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed settings: no entries, extreme thresholds and lengths, all entries.
        run_phase(16'sd0, 8'd4, 9'd0, 2);
        run_phase(16'sh7fff, 8'd4, 9'd4, 4);
        run_phase(16'sh8000, 8'd0, 9'd3, 3);
        run_phase(16'sd19661, 8'd255, 9'd1, 1);
        run_phase(16'sd16384, 8'd128, 9'd1, 1);
        run_phase(16'($urandom), 8'd1, 9'd300, 1);
        run_phase(16'sd0, 8'd1, 9'd256, 1);

        while (items_pushed < 1250)
            run_phase(16'($urandom), 8'($urandom_range(1, 16)),
                      9'($urandom_range(0, 8)), $urandom_range(3, 8));

        wait_idle();
        if (mismatches == 0 && expected_matches.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
